[rtl/decimal_line_to_seven_segment_core_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the decimal line to 7-segment core
// Concurrent checks on clock, disabled under reset or always active;
// they compile to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef DECIMAL_LINE_TO_SEVEN_SEGMENT_CORE_DEFINES_SVH
`define DECIMAL_LINE_TO_SEVEN_SEGMENT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define DL7S_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define DL7S_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define DL7S_ASSERT(label, prop, msg)
`define DL7S_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[rtl/dl7s_pkg.sv]
// ---------------------------------------------------------------------------
// dl7s_pkg
// Shared widths, codes, types and segment lookup for the decimal line
// to 7-segment core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dl7s_pkg;

   localparam int BYTE_W   = 8;
   localparam int SEG_W    = 8;
   localparam int VALUE_W  = 14;
   localparam int STATUS_W = 2;
   localparam int DIGITS   = 4;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_NUMBER = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ERROR  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NODATA = 2'd2;

   // op codes
   localparam logic OP_BYTE   = 1'b0;
   localparam logic OP_NODATA = 1'b1;

   // characters
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
   localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

   // segment patterns
   localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
   localparam logic [SEG_W-1:0] SEG_ERR   = 8'h79;
   localparam logic [SEG_W-1:0] SEG_ND0   = 8'h5E;
   localparam logic [SEG_W-1:0] SEG_ND1   = 8'h5F;
   localparam logic [SEG_W-1:0] SEG_ND2   = 8'h78;
   localparam logic [SEG_W-1:0] SEG_ND3   = 8'h80;

   typedef enum logic [3:0] {
      PH_WS     = 4'b0001,
      PH_SIGN   = 4'b0010,
      PH_DIGITS = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic                         negative;
      logic                         saturated;  // value is 10000 or more
      logic [VALUE_W-1:0]           value;      // binary, valid when not saturated
      logic [DIGITS-1:0][3:0]       digits;     // BCD, [3] is thousands
   } parse_state_type;

   typedef struct packed {
      logic [SEG_W-1:0]    seg_pos0;
      logic [SEG_W-1:0]    seg_pos1;
      logic [SEG_W-1:0]    seg_pos2;
      logic [SEG_W-1:0]    seg_pos3;
      logic [VALUE_W-1:0]  shown_value;
      logic [STATUS_W-1:0] status;
   } rsp_payload_type;

   function automatic logic [SEG_W-1:0] seg_of_digit(input logic [3:0] d);
      logic [SEG_W-1:0] s;
      case (d)
         4'd0:    s = 8'h3F;
         4'd1:    s = 8'h06;
         4'd2:    s = 8'h5B;
         4'd3:    s = 8'h4F;
         4'd4:    s = 8'h66;
         4'd5:    s = 8'h6D;
         4'd6:    s = 8'h7D;
         4'd7:    s = 8'h07;
         4'd8:    s = 8'h7F;
         4'd9:    s = 8'h6F;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

   function automatic logic is_blank(input logic [BYTE_W-1:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
             (c == CH_FF) || (c == CH_CR);
   endfunction

   function automatic rsp_payload_type nodata_payload();
      rsp_payload_type p;
      p.seg_pos0    = SEG_ND0;
      p.seg_pos1    = SEG_ND1;
      p.seg_pos2    = SEG_ND2;
      p.seg_pos3    = SEG_ND3;
      p.shown_value = '0;
      p.status      = STATUS_NODATA;
      return p;
   endfunction

   // Right-aligned digits, leading zeros blanked; all SEG_ERR if saturated or below zero.
   function automatic rsp_payload_type render_line(input parse_state_type st);
      rsp_payload_type p;
      logic            err;
      logic            zero3;
      logic            zero32;
      logic            zero321;
      err     = st.saturated || (st.negative && (st.value != '0));
      zero3   = (st.digits[3] == 4'd0);
      zero32  = zero3 && (st.digits[2] == 4'd0);
      zero321 = zero32 && (st.digits[1] == 4'd0);
      if (err) begin
         p.seg_pos0    = SEG_ERR;
         p.seg_pos1    = SEG_ERR;
         p.seg_pos2    = SEG_ERR;
         p.seg_pos3    = SEG_ERR;
         p.shown_value = '0;
         p.status      = STATUS_ERROR;
      end else begin
         p.seg_pos0    = zero3   ? SEG_BLANK : seg_of_digit(st.digits[3]);
         p.seg_pos1    = zero32  ? SEG_BLANK : seg_of_digit(st.digits[2]);
         p.seg_pos2    = zero321 ? SEG_BLANK : seg_of_digit(st.digits[1]);
         p.seg_pos3    = seg_of_digit(st.digits[0]);
         p.shown_value = st.value;
         p.status      = STATUS_NUMBER;
      end
      return p;
   endfunction

endpackage

`default_nettype wire

[rtl/dl7s_if.sv]
// ---------------------------------------------------------------------------
// dl7s channel interfaces
// Valid/ready channels for received bytes and display results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dl7s_req_if;
   import dl7s_pkg::*;
   logic              valid;
   logic              ready;
   logic              op;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface dl7s_rsp_if;
   import dl7s_pkg::*;
   logic                valid;
   logic                ready;
   logic [SEG_W-1:0]    seg_pos0;
   logic [SEG_W-1:0]    seg_pos1;
   logic [SEG_W-1:0]    seg_pos2;
   logic [SEG_W-1:0]    seg_pos3;
   logic [VALUE_W-1:0]  shown_value;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output seg_pos0, output seg_pos1, output seg_pos2,
                   output seg_pos3, output shown_value, output status, input ready);
   modport sink   (input valid, input seg_pos0, input seg_pos1, input seg_pos2,
                   input seg_pos3, input shown_value, input status, output ready);
endinterface

`default_nettype wire

[rtl/dl7s_parse.sv]
// ---------------------------------------------------------------------------
// dl7s_parse
// Line parser state: leading blanks, optional sign, decimal digits kept
// in binary and BCD, saturating once the value reaches 10000.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "decimal_line_to_seven_segment_core_defines.svh"

module dl7s_parse (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             step_i,
   input  wire                             op_i,
   input  wire [dl7s_pkg::BYTE_W-1:0]      byte_i,
   output dl7s_pkg::parse_state_type       state_o
);
   import dl7s_pkg::*;

   phase_type       phase_ff, phase_in;
   parse_state_type state_ff, state_in;

   logic                is_digit;
   logic [3:0]          digit_val;
   logic [VALUE_W+2:0]  acc_wide;
   parse_state_type     acc_state;

   assign is_digit  = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
   assign digit_val = 4'(byte_i - CH_ZERO);

   // value * 10 + digit
   assign acc_wide = {state_ff.value, 3'b000} + {2'b00, state_ff.value, 1'b0}
                     + (VALUE_W+3)'(digit_val);

   always_comb begin
      acc_state           = state_ff;
      acc_state.value     = acc_wide[VALUE_W-1:0];
      acc_state.digits    = {state_ff.digits[2:0], digit_val};
      // a nonzero thousands digit shifted out means 10000 or more
      acc_state.saturated = state_ff.saturated || (state_ff.digits[3] != 4'd0);
   end

   always_comb begin
      phase_in = phase_ff;
      state_in = state_ff;
      if (step_i && (op_i == OP_BYTE)) begin
         if (byte_i == CH_LF) begin
            phase_in = PH_WS;
            state_in = '0;
         end else begin
            case (phase_ff)
               PH_WS: begin
                  if (is_blank(byte_i)) begin
                     phase_in = PH_WS;
                  end else if ((byte_i == CH_PLUS) || (byte_i == CH_MINUS)) begin
                     state_in.negative = (byte_i == CH_MINUS);
                     phase_in          = PH_SIGN;
                  end else if (is_digit) begin
                     state_in        = '0;
                     state_in.value  = VALUE_W'(digit_val);
                     state_in.digits = {12'd0, digit_val};
                     phase_in        = PH_DIGITS;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_SIGN, PH_DIGITS: begin
                  if (is_digit) begin
                     state_in = acc_state;
                     phase_in = PH_DIGITS;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WS;
         state_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         state_ff <= state_in;
      end
   end

   assign state_o = state_ff;

   `DL7S_ASSERT(a_newline_clears,
      step_i && (op_i == OP_BYTE) && (byte_i == CH_LF) |=>
      (phase_ff == PH_WS) && (state_ff == '0),
      "newline did not clear the parse state")
   `DL7S_ASSERT(a_nodata_keeps_state,
      step_i && (op_i == OP_NODATA) |=> $stable(state_ff) && $stable(phase_ff),
      "no-data transaction changed the parse state")
   `DL7S_ASSERT(a_saturation_sticks,
      state_ff.saturated && !(step_i && (op_i == OP_BYTE) && (byte_i == CH_LF)) |=>
      state_ff.saturated,
      "saturation dropped before end of line")

endmodule

`default_nettype wire

[rtl/decimal_line_to_seven_segment_core.sv]
// ---------------------------------------------------------------------------
// decimal_line_to_seven_segment_core
// Parses newline-ended decimal lines from a byte stream and drives four
// 7-segment codes with the value, an error pattern or a no-data pattern.
// ---------------------------------------------------------------------------
// Takes one transaction per clock on req_bus while req_bus.ready is high:
// a received byte (op 0) or a no-data event (op 1). Each line is read like
// atoi (leading blanks, an optional sign, digits, rest ignored); the newline
// byte produces one rsp_bus transaction with the right-aligned digits, or
// EEEE for negative or >9999 values, and a no-data event produces the fixed
// no-data pattern. Other bytes produce nothing. A result passes through the
// input register, then the result register, before rsp valid rises. A stall
// on rsp_bus blocks req_bus only once a result-producing transaction sits in
// the input register behind the held result.
`timescale 1ns / 1ps
`default_nettype none
`include "decimal_line_to_seven_segment_core_defines.svh"

module decimal_line_to_seven_segment_core (
   input  wire         clock,
   input  wire         reset,
   dl7s_req_if.sink    req_bus,
   dl7s_rsp_if.source  rsp_bus
);
   import dl7s_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_op_ff;
   logic [BYTE_W-1:0] s1_byte_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff;

   logic              s1_result;
   logic              out_free;
   logic              s1_fire;
   logic              req_fire;
   parse_state_type   parse_state;
   rsp_payload_type   result;

   assign s1_result = (s1_op_ff == OP_NODATA) || (s1_byte_ff == CH_LF);
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign s1_fire   = s1_valid_ff && (!s1_result || out_free);
   assign req_bus.ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_bus.valid && req_bus.ready;

   dl7s_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step_i  (s1_fire),
      .op_i    (s1_op_ff),
      .byte_i  (s1_byte_ff),
      .state_o (parse_state)
   );

   // result uses the state before this transaction updates it
   assign result = (s1_op_ff == OP_NODATA) ? nodata_payload() : render_line(parse_state);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && s1_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff   <= req_bus.op;
         s1_byte_ff <= req_bus.rx_byte;
      end
      if (s1_fire && s1_result) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.seg_pos0    = rsp_data_ff.seg_pos0;
   assign rsp_bus.seg_pos1    = rsp_data_ff.seg_pos1;
   assign rsp_bus.seg_pos2    = rsp_data_ff.seg_pos2;
   assign rsp_bus.seg_pos3    = rsp_data_ff.seg_pos3;
   assign rsp_bus.shown_value = rsp_data_ff.shown_value;
   assign rsp_bus.status      = rsp_data_ff.status;

   `DL7S_ASSERT(a_result_reaches_output,
      s1_fire && s1_result |=> rsp_valid_ff,
      "result-producing transaction did not reach the output register")
   `DL7S_ASSERT(a_plain_byte_no_result,
      s1_fire && !s1_result && rsp_valid_ff && rsp_bus.ready |=> !rsp_valid_ff,
      "ordinary byte produced a result")
   `DL7S_ASSERT(a_no_overwrite,
      s1_fire && s1_result |-> !rsp_valid_ff || rsp_bus.ready,
      "held result overwritten")

endmodule

`default_nettype wire
